/* rtl/core/blhd_pkg.sv */
// ----------------------------------------------------------------------------
// blhd_pkg
// Shared types and constants for the bounded double-ended list with
// indexed delete: beat formats, operation codes and the decoded command.
// ----------------------------------------------------------------------------
package blhd_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 32;

  // Element width
  localparam int DATA_W = 32;

  // Position field width
  localparam int POS_W = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Operation codes on the request channel
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_INS_BACK  = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;

  // Request beat
  typedef struct packed {
    logic [1:0]              operation;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  // Response beat
  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                    last;
    logic                    empty_list;
    logic                    refused;
  } out_t;

  // Decoded command kinds
  typedef enum logic [1:0] {
    KIND_INS_FRONT,
    KIND_INS_BACK,
    KIND_DELETE
  } kind_t;

  // Command passed from front to back
  typedef struct packed {
    kind_t                   kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  // Head of the command queue as seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

/* rtl/core/blhd_ram.sv */
// ----------------------------------------------------------------------------
// blhd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blhd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/blhd_front.sv */
// ----------------------------------------------------------------------------
// blhd_front
// Request front end: accepts request beats, decodes the operation code and
// holds decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module blhd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  blhd_pkg::in_t    req,
  output blhd_pkg::q_head_t head,
  input  logic             pop
);

  import blhd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  logic accept;
  logic push;
  logic do_pop;
  cmd_t dec;

  // Stall only when the queue is full
  assign req_stall = (fill == QCNT_W'(QUEUE_DEPTH));
  assign accept    = req_valid && !req_stall;

  // Decode; the unused code is accepted and dropped
  always_comb begin
    dec.value    = req.value;
    dec.position = req.position;
    dec.kind     = KIND_INS_FRONT;
    push         = 1'b0;
    case (req.operation)
      OP_INS_FRONT: begin
        dec.kind = KIND_INS_FRONT;
        push     = accept;
      end
      OP_INS_BACK: begin
        dec.kind = KIND_INS_BACK;
        push     = accept;
      end
      OP_DELETE: begin
        dec.kind = KIND_DELETE;
        push     = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign do_pop     = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/blhd_back.sv */
// ----------------------------------------------------------------------------
// blhd_back
// Back end: applies commands to the ring store, closes up the list after an
// interior delete one entry per cycle, then streams the list out front to back.
// ----------------------------------------------------------------------------
module blhd_back #(
  parameter int CAPACITY = blhd_pkg::CAPACITY_DEF,
  parameter int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  blhd_pkg::q_head_t head,
  output logic              pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output blhd_pkg::out_t    rsp,
  output logic [CNT_W-1:0]  count
);

  import blhd_pkg::*;

  localparam int OFF_W = $clog2(CAPACITY + 2);
  localparam int SUM_W = OFF_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_PRIME  = 5'b00100,
    S_DUMP   = 5'b01000,
    S_SINGLE = 5'b10000
  } state_t;

  // Ring address of list offset o
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] fp,
                                            input logic [OFF_W-1:0] o);
    logic [SUM_W-1:0] s;
    s = SUM_W'(fp) + SUM_W'(o);
    if (s >= SUM_W'(2 * CAPACITY)) begin
      s = s - SUM_W'(2 * CAPACITY);
    end else if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  state_t            state, state_next;
  logic [PTR_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count_next;
  logic [OFF_W-1:0]  off, off_next;
  logic              sgl_refused, sgl_refused_next;
  logic              rsp_valid_next;
  out_t              rsp_next;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [OFF_W-1:0]  rd_off;
  logic [DATA_W-1:0] rd_data;
  logic              out_free;
  logic              load;
  logic              dump_last;
  logic              shift_done;
  logic              in_range;
  logic              tail_delete;

  blhd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (slot(front, rd_off)),
    .rd_data (rd_data)
  );

  assign out_free    = !rsp_valid || !rsp_stall;
  assign dump_last   = (CNT_W'(off) + CNT_W'(1)) == count;
  assign shift_done  = ((SUM_W'(off) + SUM_W'(2)) >= SUM_W'(count));
  assign in_range    = head.cmd.position < POS_W'(count);
  assign tail_delete = ((POS_W + 1)'(head.cmd.position) + (POS_W + 1)'(1))
                       == (POS_W + 1)'(count);

  // Sequencer
  always_comb begin
    state_next       = state;
    front_next       = front;
    count_next       = count;
    off_next         = off;
    sgl_refused_next = sgl_refused;
    pop              = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = front;
    wr_data          = head.cmd.value;
    rd_off           = off;
    load             = 1'b0;
    rsp_next         = rsp;
    case (state)
      S_IDLE: begin
        rd_off = OFF_W'(head.cmd.position) + OFF_W'(1);
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.kind)
            KIND_INS_FRONT, KIND_INS_BACK: begin
              if (count == CNT_W'(CAPACITY)) begin
                sgl_refused_next = 1'b1;
                state_next       = S_SINGLE;
              end else begin
                wr_en = 1'b1;
                if (head.cmd.kind == KIND_INS_FRONT) begin
                  front_next = (front == '0) ? PTR_W'(CAPACITY - 1)
                                             : front - PTR_W'(1);
                  wr_addr    = front_next;
                end else begin
                  wr_addr = slot(front, OFF_W'(count));
                end
                count_next = count + CNT_W'(1);
                state_next = S_PRIME;
              end
            end
            KIND_DELETE: begin
              if (in_range) begin
                if (head.cmd.position == '0) begin
                  front_next = (count == CNT_W'(1)) ? '0
                                                    : slot(front, OFF_W'(1));
                  count_next = count - CNT_W'(1);
                  state_next = S_PRIME;
                end else if (tail_delete) begin
                  count_next = count - CNT_W'(1);
                  state_next = S_PRIME;
                end else begin
                  off_next   = OFF_W'(head.cmd.position);
                  state_next = S_SHIFT;
                end
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // rd_data holds offset off+1; move it down one place
        wr_en   = 1'b1;
        wr_addr = slot(front, off);
        wr_data = rd_data;
        rd_off  = off + OFF_W'(2);
        if (shift_done) begin
          count_next = count - CNT_W'(1);
          state_next = S_PRIME;
        end else begin
          off_next = off + OFF_W'(1);
        end
      end
      S_PRIME: begin
        // Fetch the front element ahead of the dump
        rd_off   = '0;
        off_next = '0;
        if (count == '0) begin
          sgl_refused_next = 1'b0;
          state_next       = S_SINGLE;
        end else begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load                = 1'b1;
          rsp_next.element    = rd_data;
          rsp_next.last       = dump_last;
          rsp_next.empty_list = 1'b0;
          rsp_next.refused    = 1'b0;
          off_next            = off + OFF_W'(1);
          rd_off              = off + OFF_W'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          load                = 1'b1;
          rsp_next.element    = '0;
          rsp_next.last       = 1'b1;
          rsp_next.empty_list = !sgl_refused;
          rsp_next.refused    = sgl_refused;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register holds its beat while stalled
  assign rsp_valid_next = load ? 1'b1 : (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front       <= '0;
      count       <= '0;
      sgl_refused <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front       <= front_next;
      count       <= count_next;
      sgl_refused <= sgl_refused_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    off <= off_next;
    rsp <= rsp_next;
  end

endmodule

/* rtl/core/bounded_list_head_tail_indexed_delete.sv */
// ----------------------------------------------------------------------------
// bounded_list_head_tail_indexed_delete
// Ordered list of up to CAPACITY signed values with front/back insert and
// delete by position; every successful operation streams out the list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req): one beat per operation.
//   operation 0 inserts value at the front, 1 at the back, 2 deletes the
//   element at position; code 3 is taken and dropped.
//   Response channel (rsp_valid/rsp_stall/rsp): after a successful
//   operation the whole list comes out front to back, one beat per element,
//   last set on the final beat. An empty list gives one beat with
//   empty_list set; an insert into a full list gives one beat with refused
//   set; a delete out of range gives nothing.
//   Timing: a two-entry command queue decouples the request side from the
//   back end. An insert takes its command from the queue and writes the
//   store in the same cycle, primes the store read, then sends one beat a
//   cycle while the receiver does not stall; a delete inside the list first
//   moves each later element down one place, one element per cycle.
//   A stalled response holds its beat and keeps the back end from sending
//   more; requests keep being taken until the queue fills. Reset empties
//   the list and the queue; the store contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_list_head_tail_indexed_delete #(
  parameter int CAPACITY = blhd_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  blhd_pkg::in_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output blhd_pkg::out_t rsp
);

  import blhd_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  q_head_t          head;
  logic             pop;
  logic [CNT_W-1:0] count;

  blhd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .pop       (pop)
  );

  blhd_back #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .count     (count)
  );

  // List never grows past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  // Empty and refused beats stand alone and close their dump
  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.refused || rsp.empty_list) |-> rsp.last)
    else $error("flagged beat without last");

  // Never both empty and refused
  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.refused && rsp.empty_list))
    else $error("empty and refused together");

endmodule

/* verif/tb_bounded_list_head_tail_indexed_delete.sv */
// ----------------------------------------------------------------------------
// tb_bounded_list_head_tail_indexed_delete
// Self-checking bench for the bounded double-ended list. A behavioral list
// model predicts the dump beats of every accepted operation; a checker
// compares each response beat with the oldest prediction. Directed tests
// cover empty, full and out-of-range cases, then random fill/drain traffic
// runs with sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bounded_list_head_tail_indexed_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import blhd_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int QUIET_CYCLES = 2 * LIST_CAP + 16;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  // List contents as the block should hold them, front first
  logic signed [DATA_W-1:0] list_model[$];
  // Beats still owed by the block, oldest first
  out_t expected_beats[$];
  int dumps_predicted = 0;
  int errors = 0;

  // Traffic shaping knobs
  int stall_pct = 25;
  bit sender_gaps = 1'b1;
  int burst_left = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int run_left = 0;
  int idle_cycles = 0;

  bounded_list_head_tail_indexed_delete DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic string beat_text(input out_t b);
    return $sformatf("element %0d last %b empty_list %b refused %b",
                     b.element, b.last, b.empty_list, b.refused);
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Apply one accepted operation to the list model and queue its dump
  function automatic void predict_list_op(input in_t item);
    out_t beat;
    beat = '0;
    case (item.operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (list_model.size() >= LIST_CAP) begin
          // full: list untouched, one refused beat
          beat.last = 1'b1;
          beat.refused = 1'b1;
          expected_beats.push_back(beat);
          dumps_predicted++;
          return;
        end
        if (item.operation == OP_INS_FRONT) list_model.push_front(item.value);
        else list_model.push_back(item.value);
      end
      OP_DELETE: begin
        if (item.position >= list_model.size()) return;
        list_model.delete(item.position);
      end
      default: return;
    endcase
    if (list_model.size() == 0) begin
      beat.last = 1'b1;
      beat.empty_list = 1'b1;
      expected_beats.push_back(beat);
    end else begin
      for (int i = 0; i < list_model.size(); i++) begin
        beat.element = list_model[i];
        beat.last = (i == list_model.size() - 1);
        expected_beats.push_back(beat);
      end
    end
    dumps_predicted++;
  endfunction

  // Send one request beat; entered and left at a falling edge
  task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                         input logic [POS_W-1:0] pos);
    in_t item;
    int gap;
    item.operation = op;
    item.value = val;
    item.position = pos;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = sender_gaps ? $urandom_range(6, 0) : 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_list_op(item);
    @(negedge clk);
  endtask

  // Sender pauses until the block has delivered every owed beat
  task automatic wait_list_idle();
    req_valid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  // One random operation, mostly well formed, biased by insert_pct
  task automatic send_random_op(input int insert_pct);
    int roll;
    int n;
    logic signed [DATA_W-1:0] val;
    roll = $urandom_range(99, 0);
    n = list_model.size();
    case ($urandom_range(9, 0))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7FFF_FFFF;
      2: val = -1;
      default: val = $urandom;
    endcase
    if (roll < 4) begin
      send_op(OP_UNUSED, val, POS_W'($urandom));
    end else if (roll < 10) begin
      // delete at or past the end: dropped
      send_op(OP_DELETE, val, POS_W'($urandom_range(16'hFFFF, n)));
    end else if (roll < 10 + insert_pct || n == 0) begin
      send_op($urandom_range(1, 0) ? OP_INS_BACK : OP_INS_FRONT, val,
              POS_W'($urandom));
    end else begin
      send_op(OP_DELETE, val, POS_W'($urandom_range(n - 1, 0)));
    end
  endtask

  task automatic run_random_ops(input int dumps, input int insert_pct);
    int start;
    start = dumps_predicted;
    while (dumps_predicted - start < dumps) send_random_op(insert_pct);
  endtask

  // Deletes and an unused code on an empty list give nothing
  task automatic test_empty_list_drops();
    send_op(OP_DELETE, 32'sd0, 16'd0);
    send_op(OP_DELETE, -32'sd1, 16'hFFFF);
    send_op(OP_UNUSED, 32'sh5A5A_A5A5, 16'h1234);
    wait_list_idle();
  endtask

  // Front/back inserts with extreme values, deletes at each end and inside
  task automatic test_insert_delete_basics();
    send_op(OP_INS_FRONT, 32'sh8000_0000, 16'hFFFF);
    send_op(OP_INS_BACK, 32'sh7FFF_FFFF, 16'h0000);
    send_op(OP_INS_FRONT, -32'sd1, 16'hA5A5);
    send_op(OP_INS_BACK, 32'sd0, 16'h5A5A);
    send_op(OP_INS_FRONT, 32'sd1, 16'd0);
    send_op(OP_DELETE, 32'sd0, 16'd2);
    send_op(OP_DELETE, 32'sd0, 16'd4);
    send_op(OP_DELETE, 32'sd0, 16'd3);
    send_op(OP_DELETE, 32'sd0, 16'd0);
    send_op(OP_UNUSED, -32'sd1, 16'hFFFF);
    send_op(OP_DELETE, 32'sd0, 16'd1);
    send_op(OP_DELETE, 32'sd0, 16'd0);
    send_op(OP_DELETE, 32'sd0, 16'd0);
    send_op(OP_INS_BACK, 32'sd42, 16'd0);
    send_op(OP_DELETE, 32'sd0, 16'd0);
    wait_list_idle();
  endtask

  // Fill the list while the receiver holds off, then refuse and trim
  task automatic test_full_list_under_hold();
    hold_token++;
    for (int i = 0; i < LIST_CAP; i++) begin
      send_op((i % 3 == 0) ? OP_INS_FRONT : OP_INS_BACK, $urandom, POS_W'($urandom));
    end
    send_op(OP_INS_FRONT, $urandom, 16'd0);
    send_op(OP_INS_BACK, $urandom, 16'd0);
    send_op(OP_DELETE, 32'sd0, POS_W'(LIST_CAP - 1));
    send_op(OP_DELETE, 32'sd0, POS_W'(LIST_CAP - 1));
    send_op(OP_INS_BACK, $urandom, 16'd0);
    send_op(OP_DELETE, 32'sd0, 16'd0);
    send_op(OP_DELETE, 32'sd0, POS_W'(LIST_CAP - 2));
    send_op(OP_DELETE, 32'sd0, POS_W'(LIST_CAP / 2));
    wait_list_idle();
  endtask

  // Random fill and drain, with and without idling
  task automatic test_random_traffic();
    run_random_ops(140, 65);
    run_random_ops(140, 30);
    wait_list_idle();
    stall_pct = 0;
    sender_gaps = 1'b0;
    run_random_ops(45, 50);
    stall_pct = 70;
    sender_gaps = 1'b1;
    run_random_ops(45, 50);
    wait_list_idle();
  endtask

  // Receiver: long hold on request, otherwise stall runs of random length
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      run_left <= $urandom_range(3, 0);
    end
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_beats.size() == 0) begin
        note_failure($sformatf("unexpected beat: %s", beat_text(rsp)));
      end else begin
        want = expected_beats.pop_front();
        if (rsp.element !== want.element || rsp.last !== want.last ||
            rsp.empty_list !== want.empty_list || rsp.refused !== want.refused) begin
          note_failure($sformatf("expected %s, got %s", beat_text(want), beat_text(rsp)));
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bounded_list_head_tail_indexed_delete regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_list_drops();
    test_insert_delete_basics();
    test_full_list_under_hold();
    test_random_traffic();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("bounded_list_head_tail_indexed_delete regression: pass");
    end else begin
      $display("bounded_list_head_tail_indexed_delete regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/blhd_pkg.sv
rtl/core/blhd_ram.sv
rtl/core/blhd_front.sv
rtl/core/blhd_back.sv
rtl/core/bounded_list_head_tail_indexed_delete.sv
verif/tb_bounded_list_head_tail_indexed_delete.sv
